// ===== hdl/positional_pid_multimode_unit_defines.svh =====
// ------------------------------------------------------------------------
// Assertion macros for the positional PID unit
// Shared property shorthands, clocked on clk_i and held off during reset.
// ------------------------------------------------------------------------
`ifndef POSITIONAL_PID_MULTIMODE_UNIT_DEFINES_SVH
`define POSITIONAL_PID_MULTIMODE_UNIT_DEFINES_SVH

// same-cycle implication
`define PPMU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppmu assertion failed");

// next-cycle implication
`define PPMU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppmu assertion failed");

`endif

// ===== hdl/ppmu_pkg.sv =====
// ------------------------------------------------------------------------
// ppmu_pkg
// Types, constants and helpers of the positional PID unit.
// ------------------------------------------------------------------------
`default_nettype none
package ppmu_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  localparam int ACC_W   = 64;  // working width of the shared adder
  localparam int ST_W    = 40;  // integral and filter state
  localparam int GAIN_W  = 16;
  localparam int ALPHA_W = 9;
  localparam int MODE_W  = 4;
  localparam int OFF_W   = 7;
  localparam int DRIVE_W = 8;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 16;
  localparam int LP_SH   = 8;   // alpha is Q1.8
  localparam int DRIVE_MAX = 100;

  typedef enum logic [IDX_W-1:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KD     = 3'd2,
    REG_ALPHA  = 3'd3,
    REG_MODE   = 3'd4,
    REG_DZ     = 3'd5,
    REG_BOUND  = 3'd6,
    REG_OFFSET = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    IM_VAR   = 2'd0,
    IM_SEP   = 2'd1,
    IM_CLAMP = 2'd2,
    IM_HOLD  = 2'd3
  } imode_e;

  typedef enum logic [1:0] {
    DM_MEAS  = 2'd0,
    DM_FERR  = 2'd1,
    DM_FMEAS = 2'd2,
    DM_PLAIN = 2'd3
  } dmode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_IADD,
    ST_DSET,
    ST_MUL,
    ST_MEND,
    ST_ISUM,
    ST_OFFS,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_D,
    MUL_LP,
    MUL_P,
    MUL_I
  } mul_e;

  typedef struct packed {
    logic [ACC_W-1:0] a;
    logic [ACC_W-1:0] b;
    logic             sub;
  } alu_op_t;

  // saturate a working value to the signed state width
  function automatic logic [ST_W-1:0] sat_st(input logic [ACC_W-1:0] v);
    logic [ST_W-1:0] r;
    if ((&v[ACC_W-1:ST_W-1]) || !(|v[ACC_W-1:ST_W-1])) begin
      r = v[ST_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ST_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/positional_pid_multimode_unit.sv =====
// ------------------------------------------------------------------------
// positional_pid_multimode_unit
// Positional PID with selectable integral and derivative variants, worked
// out by a small sequencer around one shared adder.
// ------------------------------------------------------------------------
//   channel   direction  beat content
//   s_axis    in         tdata: setpoint, measured
//   m_axis    out        tdata: drive; tuser: in_deadzone
//   cfg       in         cfg_idx_i selects, cfg_data_i written when cfg_we_i
//
// Outside the deadzone three 16-bit products run one multiplier bit per
// cycle through the shared adder, the variable-speed integral adds a
// DATA_WIDTH+1+FRAC_BITS step divider and the filtered derivatives add
// a 9-step alpha product. Inside the deadzone a beat goes from the check
// straight to the end.
// Reset clears configuration, history and control. A result waits in the
// output register while the next beat is accepted; a stalled output holds
// the sequencer at its end.
`default_nettype none
module positional_pid_multimode_unit #(
  parameter int DATA_WIDTH = ppmu_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = ppmu_pkg::FRAC_BITS_DEF,
  localparam int S_TDATA_W = ((2*DATA_WIDTH+7)/8)*8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [S_TDATA_W-1:0]         s_axis_tdata_i,  // setpoint, measured
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [ppmu_pkg::DRIVE_W-1:0] m_axis_tdata_o,  // drive
  output logic                         m_axis_tuser_o,  // in_deadzone
  input  logic                         cfg_we_i,
  input  logic [ppmu_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [ppmu_pkg::CFG_W-1:0]   cfg_data_i
);

  localparam int ACC_W = ppmu_pkg::ACC_W;
  localparam int ST_W  = ppmu_pkg::ST_W;
  localparam int EW    = DATA_WIDTH + 1;
  localparam int DIV_N = EW + FRAC_BITS;
  localparam int CNT_W = $clog2((DIV_N > ppmu_pkg::GAIN_W ? DIV_N : ppmu_pkg::GAIN_W) + 1);
  localparam logic [ACC_W-1:0] LIM_OUT = ACC_W'(ppmu_pkg::DRIVE_MAX) << FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ONE_Q = ACC_W'(1) << FRAC_BITS;

  // configuration
  logic [ppmu_pkg::GAIN_W-1:0]  kp_q, ki_q, kd_q;
  logic [ppmu_pkg::ALPHA_W-1:0] alpha_q;
  logic [ppmu_pkg::MODE_W-1:0]  mode_q;
  logic [ppmu_pkg::CFG_W-1:0]   dz_q, bound_q;
  logic [ppmu_pkg::OFF_W-1:0]   off_q;

  // state and working registers
  ppmu_pkg::state_e state_q, state_d;
  ppmu_pkg::mul_e   phase_q, phase_d;
  logic [EW-1:0]    prev_err_q, prev_err_d;
  logic [DATA_WIDTH-1:0] last_meas_q, last_meas_d;
  logic [ST_W-1:0]  integ_q, integ_d, filt_q, filt_d;
  logic [EW-1:0]    e_q, e_d, ae_q, ae_d, dm_q, dm_d;
  logic [EW:0]      de_q, de_d, dv_q, dv_d, rem_q, rem_d;
  logic [DIV_N-1:0] num_q, num_d, quo_q, quo_d;
  logic [ACC_W-1:0] acc_q, acc_d, m_q, m_d, pd_q, pd_d, add_q, add_d;
  logic [ppmu_pkg::GAIN_W-1:0] b_q, b_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             dzhit_q, dzhit_d;
  logic             ovalid_q, ovalid_d, odz_q, odz_d;
  logic [ppmu_pkg::DRIVE_W-1:0] drive_q, drive_d;

  ppmu_pkg::alu_op_t alu_op;
  logic [ACC_W-1:0]  alu_res;

  ppmu_alu u_alu (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  assign s_axis_tready_o = (state_q == ppmu_pkg::ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = drive_q;
  assign m_axis_tuser_o  = odz_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      alpha_q <= '0;
      mode_q  <= '0;
      dz_q    <= '0;
      bound_q <= '0;
      off_q   <= '0;
    end else if (cfg_we_i) begin
      case (ppmu_pkg::reg_idx_e'(cfg_idx_i))
        ppmu_pkg::REG_KP:     kp_q    <= cfg_data_i;
        ppmu_pkg::REG_KI:     ki_q    <= cfg_data_i;
        ppmu_pkg::REG_KD:     kd_q    <= cfg_data_i;
        ppmu_pkg::REG_ALPHA:  alpha_q <= cfg_data_i[ppmu_pkg::ALPHA_W-1:0];
        ppmu_pkg::REG_MODE:   mode_q  <= cfg_data_i[ppmu_pkg::MODE_W-1:0];
        ppmu_pkg::REG_DZ:     dz_q    <= cfg_data_i;
        ppmu_pkg::REG_BOUND:  bound_q <= cfg_data_i;
        ppmu_pkg::REG_OFFSET: off_q   <= cfg_data_i[ppmu_pkg::OFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppmu_pkg::ST_IDLE;
      phase_q     <= ppmu_pkg::MUL_D;
      prev_err_q  <= '0;
      last_meas_q <= '0;
      integ_q     <= '0;
      filt_q      <= '0;
      ovalid_q    <= 1'b0;
      cnt_q       <= '0;
      dzhit_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      prev_err_q  <= prev_err_d;
      last_meas_q <= last_meas_d;
      integ_q     <= integ_d;
      filt_q      <= filt_d;
      ovalid_q    <= ovalid_d;
      cnt_q       <= cnt_d;
      dzhit_q     <= dzhit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q     <= e_d;
    ae_q    <= ae_d;
    dm_q    <= dm_d;
    de_q    <= de_d;
    dv_q    <= dv_d;
    rem_q   <= rem_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    acc_q   <= acc_d;
    m_q     <= m_d;
    pd_q    <= pd_d;
    add_q   <= add_d;
    b_q     <= b_d;
    odz_q   <= odz_d;
    drive_q <= drive_d;
  end

  always_comb begin
    logic [EW-1:0]    sp_x, ms_x;
    logic [ACC_W-1:0] e_x, s_ext, lim, clp;
    logic [ST_W-1:0]  sat_v;
    logic [EW+1:0]    trial;
    logic [DIV_N-1:0] q_fin;
    logic [ppmu_pkg::ALPHA_W-1:0] a_cl;
    ppmu_pkg::imode_e im;
    ppmu_pkg::dmode_e dmd;

    sp_x  = {s_axis_tdata_i[DATA_WIDTH-1], s_axis_tdata_i[DATA_WIDTH-1:0]};
    ms_x  = {s_axis_tdata_i[2*DATA_WIDTH-1], s_axis_tdata_i[2*DATA_WIDTH-1:DATA_WIDTH]};
    e_x   = ACC_W'($signed(e_q));
    im    = ppmu_pkg::imode_e'(mode_q[3:2]);
    dmd   = ppmu_pkg::dmode_e'(mode_q[1:0]);
    a_cl  = (alpha_q > ppmu_pkg::ALPHA_W'(256)) ? ppmu_pkg::ALPHA_W'(256) : alpha_q;
    trial = {rem_q, num_q[DIV_N-1]};
    q_fin = {quo_q[DIV_N-2:0], 1'b0};
    s_ext = '0;
    sat_v = '0;
    lim   = '0;
    clp   = '0;

    state_d     = state_q;
    phase_d     = phase_q;
    prev_err_d  = prev_err_q;
    last_meas_d = last_meas_q;
    integ_d     = integ_q;
    filt_d      = filt_q;
    e_d   = e_q;
    ae_d  = ae_q;
    dm_d  = dm_q;
    de_d  = de_q;
    dv_d  = dv_q;
    rem_d = rem_q;
    num_d = num_q;
    quo_d = quo_q;
    acc_d = acc_q;
    m_d   = m_q;
    pd_d  = pd_q;
    add_d = add_q;
    b_d   = b_q;
    cnt_d = cnt_q;
    dzhit_d = dzhit_q;
    odz_d   = odz_q;
    drive_d = drive_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;

    alu_op.a   = acc_q;
    alu_op.b   = '0;
    alu_op.sub = 1'b0;

    case (state_q)
      ppmu_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          e_d  = sp_x - ms_x;
          ae_d = e_d[EW-1] ? (~e_d + EW'(1)) : e_d;
          dm_d = ms_x - {last_meas_q[DATA_WIDTH-1], last_meas_q};
          de_d = {e_d[EW-1], e_d} - {prev_err_q[EW-1], prev_err_q};
          prev_err_d  = e_d;
          last_meas_d = s_axis_tdata_i[2*DATA_WIDTH-1:DATA_WIDTH];
          state_d     = ppmu_pkg::ST_CHECK;
        end
      end

      ppmu_pkg::ST_CHECK: begin
        dzhit_d = (ACC_W'(ae_q) < ACC_W'(dz_q));
        add_d   = e_x <<< FRAC_BITS;
        if (dzhit_d) begin
          state_d = ppmu_pkg::ST_DONE;
        end else begin
          case (im)
            ppmu_pkg::IM_VAR: begin
              dv_d    = {1'b0, ae_q} + (EW+1)'(1);
              rem_d   = '0;
              quo_d   = '0;
              num_d   = {ae_q, {FRAC_BITS{1'b0}}};
              cnt_d   = CNT_W'(DIV_N);
              state_d = ppmu_pkg::ST_DIV;
            end
            ppmu_pkg::IM_SEP, ppmu_pkg::IM_CLAMP: state_d = ppmu_pkg::ST_IADD;
            default: state_d = ppmu_pkg::ST_DSET;
          endcase
        end
      end

      // restoring division, one quotient bit a cycle
      ppmu_pkg::ST_DIV: begin
        alu_op.a   = ACC_W'(trial);
        alu_op.b   = ACC_W'(dv_q);
        alu_op.sub = 1'b1;
        num_d = {num_q[DIV_N-2:0], 1'b0};
        if (!alu_res[ACC_W-1]) begin
          rem_d = alu_res[EW:0];
          quo_d = {quo_q[DIV_N-2:0], 1'b1};
        end else begin
          rem_d = trial[EW:0];
          quo_d = {quo_q[DIV_N-2:0], 1'b0};
        end
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          q_fin   = quo_d;
          add_d   = e_q[EW-1] ? (~ACC_W'(q_fin) + ACC_W'(1)) : ACC_W'(q_fin);
          state_d = ppmu_pkg::ST_IADD;
        end
      end

      ppmu_pkg::ST_IADD: begin
        alu_op.a = ACC_W'($signed(integ_q));
        alu_op.b = add_q;
        sat_v    = ppmu_pkg::sat_st(alu_res);
        lim      = ACC_W'(bound_q) << FRAC_BITS;
        case (im)
          ppmu_pkg::IM_SEP: begin
            integ_d = (ACC_W'(ae_q) < ACC_W'(bound_q)) ? sat_v : '0;
          end
          ppmu_pkg::IM_CLAMP: begin
            s_ext = ACC_W'($signed(sat_v));
            if ($signed(s_ext) > $signed(lim)) begin
              integ_d = lim[ST_W-1:0];
            end else if ($signed(s_ext) < -$signed(lim)) begin
              integ_d = ST_W'(-$signed(lim));
            end else begin
              integ_d = sat_v;
            end
          end
          default: integ_d = sat_v;
        endcase
        state_d = ppmu_pkg::ST_DSET;
      end

      ppmu_pkg::ST_DSET: begin
        if (dmd == ppmu_pkg::DM_MEAS || dmd == ppmu_pkg::DM_FMEAS) begin
          m_d = -ACC_W'($signed(dm_q));
        end else begin
          m_d = ACC_W'($signed(de_q));
        end
        b_d     = kd_q;
        acc_d   = '0;
        cnt_d   = CNT_W'(ppmu_pkg::GAIN_W);
        phase_d = ppmu_pkg::MUL_D;
        state_d = ppmu_pkg::ST_MUL;
      end

      // shift-add multiply, one multiplier bit a cycle
      ppmu_pkg::ST_MUL: begin
        alu_op.a = acc_q;
        alu_op.b = b_q[0] ? m_q : '0;
        acc_d = alu_res;
        m_d   = m_q << 1;
        b_d   = b_q >> 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = ppmu_pkg::ST_MEND;
        end
      end

      ppmu_pkg::ST_MEND: begin
        case (phase_q)
          ppmu_pkg::MUL_D: begin
            if (dmd == ppmu_pkg::DM_FERR || dmd == ppmu_pkg::DM_FMEAS) begin
              // low-pass as raw*256 + alpha*(old - raw)
              alu_op.a   = ACC_W'($signed(filt_q));
              alu_op.b   = acc_q;
              alu_op.sub = 1'b1;
              m_d     = alu_res;
              acc_d   = acc_q << ppmu_pkg::LP_SH;
              b_d     = ppmu_pkg::GAIN_W'(a_cl);
              cnt_d   = CNT_W'(ppmu_pkg::ALPHA_W);
              phase_d = ppmu_pkg::MUL_LP;
              state_d = ppmu_pkg::ST_MUL;
            end else begin
              if (dmd == ppmu_pkg::DM_MEAS) begin
                filt_d = ppmu_pkg::sat_st(acc_q);
                acc_d  = ACC_W'($signed(filt_d));
              end
              m_d     = e_x;
              b_d     = kp_q;
              cnt_d   = CNT_W'(ppmu_pkg::GAIN_W);
              phase_d = ppmu_pkg::MUL_P;
              state_d = ppmu_pkg::ST_MUL;
            end
          end
          ppmu_pkg::MUL_LP: begin
            filt_d  = ppmu_pkg::sat_st(ACC_W'($signed(acc_q) >>> ppmu_pkg::LP_SH));
            acc_d   = ACC_W'($signed(filt_d));
            m_d     = e_x;
            b_d     = kp_q;
            cnt_d   = CNT_W'(ppmu_pkg::GAIN_W);
            phase_d = ppmu_pkg::MUL_P;
            state_d = ppmu_pkg::ST_MUL;
          end
          ppmu_pkg::MUL_P: begin
            pd_d    = acc_q;
            acc_d   = '0;
            m_d     = ACC_W'($signed(integ_q));
            b_d     = ki_q;
            cnt_d   = CNT_W'(ppmu_pkg::GAIN_W);
            phase_d = ppmu_pkg::MUL_I;
            state_d = ppmu_pkg::ST_MUL;
          end
          default: state_d = ppmu_pkg::ST_ISUM;
        endcase
      end

      ppmu_pkg::ST_ISUM: begin
        alu_op.a = pd_q;
        alu_op.b = ACC_W'($signed(acc_q) >>> FRAC_BITS);
        acc_d    = alu_res;
        state_d  = ppmu_pkg::ST_OFFS;
      end

      // friction offset: a sum of zero or less takes the negative side
      ppmu_pkg::ST_OFFS: begin
        alu_op.a   = acc_q;
        alu_op.b   = ACC_W'(off_q) << FRAC_BITS;
        alu_op.sub = !(!acc_q[ACC_W-1] && (|acc_q));
        acc_d      = alu_res;
        state_d    = ppmu_pkg::ST_DONE;
      end

      ppmu_pkg::ST_DONE: begin
        if (!ovalid_q || m_axis_tready_i) begin
          if ($signed(acc_q) > $signed(LIM_OUT)) begin
            clp = LIM_OUT;
          end else if ($signed(acc_q) < -$signed(LIM_OUT)) begin
            clp = -LIM_OUT;
          end else begin
            clp = acc_q;
          end
          drive_d  = dzhit_q ? '0 : ppmu_pkg::DRIVE_W'($signed(clp) / ONE_Q);
          odz_d    = dzhit_q;
          ovalid_d = 1'b1;
          state_d  = ppmu_pkg::ST_IDLE;
        end
      end

      default: state_d = ppmu_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/ppmu_alu.sv =====
// ------------------------------------------------------------------------
// ppmu_alu
// Shared add/subtract unit driven by the sequencer every cycle.
// ------------------------------------------------------------------------
`default_nettype none
module ppmu_alu (
  input  var ppmu_pkg::alu_op_t         op_i,
  output logic [ppmu_pkg::ACC_W-1:0]    res_o
);

  logic [ppmu_pkg::ACC_W-1:0] b_sel;

  assign b_sel = op_i.sub ? ~op_i.b : op_i.b;
  assign res_o = op_i.a + b_sel + {{(ppmu_pkg::ACC_W-1){1'b0}}, op_i.sub};

endmodule
`default_nettype wire

// ===== hdl/ppmu_checker.sv =====
// ------------------------------------------------------------------------
// ppmu_checker
// Port-level checks of the positional PID unit, bound to the top level.
// ------------------------------------------------------------------------
`default_nettype none
`include "positional_pid_multimode_unit_defines.svh"
module ppmu_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [ppmu_pkg::DRIVE_W-1:0] m_axis_tdata_o,
  input logic                         m_axis_tuser_o
);

  logic drive_ok;
  logic out_stall;

  assign drive_ok  = ($signed(m_axis_tdata_o) <= 8'sd100) &&
                     ($signed(m_axis_tdata_o) >= -8'sd100);
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // a deadzone beat carries no drive
  `PPMU_ASSERT_IMP(a_dz_zero, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == '0)

  // drive stays inside the clamp
  `PPMU_ASSERT_IMP(a_range, m_axis_tvalid_o, drive_ok)

  // one beat at a time: busy after an accepted beat
  `PPMU_ASSERT_NXT(a_busy, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)

  // hold a stalled result
  `PPMU_ASSERT_NXT(a_hold, out_stall, m_axis_tvalid_o && $stable({m_axis_tuser_o, m_axis_tdata_o}))

endmodule

bind positional_pid_multimode_unit ppmu_checker u_ppmu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ------------------------------------------------------------------------
// Positional PID unit testbench
// Drives setpoint/measured beats through the stream port and checks every
// drive beat against a cycle-free model of the controller. Gains, modes,
// deadzone, bound and offset are rewritten between phases while idle.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam longint ST_HI = 64'sh7F_FFFF_FFFF;
  localparam longint ST_LO = -ST_HI - 1;

  typedef struct packed {
    logic [7:0] drive;
    logic       dz;
  } drive_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [31:0] s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [7:0] m_data;
  logic m_user;
  logic cfg_we = 1'b0;
  logic [ppmu_pkg::IDX_W-1:0] cfg_idx = '0;
  logic [ppmu_pkg::CFG_W-1:0] cfg_data = '0;

  positional_pid_multimode_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // controller copy
  longint kp, ki, kd, alpha, dz_lim, bound, offs;
  logic [3:0] mode_r;
  longint prev_e, isum, dfilt, last_m;

  logic [31:0] pending_q[$];
  drive_t      drive_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_dz = 0;

  function automatic longint sat40(longint v);
    if (v > ST_HI) return ST_HI;
    if (v < ST_LO) return ST_LO;
    return v;
  endfunction

  function automatic longint floor_sh(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint low_pass(longint raw, longint old);
    longint a;
    a = (alpha > 256) ? 256 : alpha;
    return sat40(floor_sh((256 - a) * raw + a * old, 8));
  endfunction

  task automatic predict_drive(input logic [31:0] beat);
    longint sp, ms, e, ae, old_e, old_m, dt, sum, lim;
    drive_t r;
    sp = longint'($signed(beat[15:0]));
    ms = longint'($signed(beat[31:16]));
    e = sp - ms;
    ae = (e < 0) ? -e : e;
    old_e = prev_e;
    old_m = last_m;
    prev_e = e;
    last_m = ms;
    if (ae < dz_lim) begin
      r.drive = 8'd0;
      r.dz = 1'b1;
    end else begin
      case (ppmu_pkg::imode_e'(mode_r[3:2]))
        ppmu_pkg::IM_VAR: isum = sat40(isum + (e * 256) / (ae + 1));
        ppmu_pkg::IM_SEP: isum = (ae < bound) ? sat40(isum + e * 256) : 0;
        ppmu_pkg::IM_CLAMP: begin
          lim = bound * 256;
          isum = sat40(isum + e * 256);
          if (isum > lim) isum = lim;
          if (isum < -lim) isum = -lim;
        end
        default: ;
      endcase
      case (ppmu_pkg::dmode_e'(mode_r[1:0]))
        ppmu_pkg::DM_MEAS: begin
          dfilt = sat40(-kd * (ms - old_m));
          dt = dfilt;
        end
        ppmu_pkg::DM_FERR: begin
          dfilt = low_pass(kd * (e - old_e), dfilt);
          dt = dfilt;
        end
        ppmu_pkg::DM_FMEAS: begin
          dfilt = low_pass(-kd * (ms - old_m), dfilt);
          dt = dfilt;
        end
        default: dt = kd * (e - old_e);
      endcase
      sum = kp * e + floor_sh(ki * isum, FB) + dt;
      if (sum > 0) sum += offs * 256;
      else sum -= offs * 256;
      if (sum > 25600) sum = 25600;
      if (sum < -25600) sum = -25600;
      r.drive = 8'(sum / 256);
      r.dz = 1'b0;
    end
    drive_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s at result %0d: got %0d want %0d", what, n_got, got, want);
  endtask

  // accept flag sampled at the rising edge for the driver
  logic s_ready_q = 1'b0;
  always @(posedge clk_i) begin
    s_ready_q <= s_valid && s_ready;
    if (s_valid && s_ready) begin
      predict_drive(s_data);
      n_sent++;
    end
  end

  // driver
  int s_gap = 0;
  always @(negedge clk_i) begin
    if (s_valid && s_ready_q) begin
      s_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : 0;
    end
    if (!s_valid || s_ready_q) begin
      if (s_gap > 0) begin
        s_gap--;
        s_valid <= 1'b0;
      end else if (pending_q.size() > 0 && rst_ni) begin
        s_data <= pending_q.pop_front();
        s_valid <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // monitor
  int m_gap = 0;
  always @(posedge clk_i) begin
    if (m_valid && m_ready) begin
      n_got++;
      if (drive_q.size() == 0) begin
        report_mismatch("unexpected beat", m_data, 0);
      end else begin
        drive_t w;
        w = drive_q.pop_front();
        if (m_data !== w.drive)
          report_mismatch("drive", $signed(m_data), $signed(w.drive));
        if (m_user !== w.dz) report_mismatch("in_deadzone", m_user, w.dz);
        if (w.dz) n_dz++;
      end
    end
  end

  logic m_took = 1'b0;
  always @(posedge clk_i) m_took <= m_valid && m_ready;
  always @(negedge clk_i) begin
    if (m_took) m_gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 16) : 0;
    if (m_gap > 0) begin
      m_gap--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  task automatic write_reg(input ppmu_pkg::reg_idx_e idx, input int val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= ppmu_pkg::CFG_W'(val);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      ppmu_pkg::REG_KP: kp = val & 16'hFFFF;
      ppmu_pkg::REG_KI: ki = val & 16'hFFFF;
      ppmu_pkg::REG_KD: kd = val & 16'hFFFF;
      ppmu_pkg::REG_ALPHA: alpha = val & 9'h1FF;
      ppmu_pkg::REG_MODE: mode_r = 4'(val);
      ppmu_pkg::REG_DZ: dz_lim = val & 16'hFFFF;
      ppmu_pkg::REG_BOUND: bound = val & 16'hFFFF;
      default: offs = val & 7'h7F;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || s_valid || drive_q.size() > 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pack_beat(input int sp, input int ms);
    return {16'(ms), 16'(sp)};
  endfunction

  // random setting, extremes mixed in
  task automatic random_setting(input int ph);
    int m;
    m = $urandom_range(0, 15);
    write_reg(ppmu_pkg::REG_KP, ph % 4 == 0 ? 65535 : $urandom_range(0, 2048));
    write_reg(ppmu_pkg::REG_KI, ph % 5 == 0 ? 65535 : $urandom_range(0, 512));
    write_reg(ppmu_pkg::REG_KD, ph % 6 == 0 ? 65535 : $urandom_range(0, 1024));
    write_reg(ppmu_pkg::REG_ALPHA, ph % 3 == 0 ? 511 : $urandom_range(0, 256));
    write_reg(ppmu_pkg::REG_MODE, m);
    write_reg(ppmu_pkg::REG_DZ, ph % 7 == 0 ? 65535 : $urandom_range(0, 3) == 0 ? 0 :
              $urandom_range(0, 64));
    write_reg(ppmu_pkg::REG_BOUND, ph % 4 == 1 ? 65535 : $urandom_range(0, 300));
    write_reg(ppmu_pkg::REG_OFFSET, ph % 3 == 2 ? 127 : $urandom_range(0, 100));
  endtask

  initial begin
    int sp, ms;
    kp = 0; ki = 0; kd = 0; alpha = 0; mode_r = 0; dz_lim = 0; bound = 0; offs = 0;
    prev_e = 0; isum = 0; dfilt = 0; last_m = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: field extremes across every mode
    for (int m = 0; m < 16; m++) begin
      write_reg(ppmu_pkg::REG_KP, 256);
      write_reg(ppmu_pkg::REG_KI, 128);
      write_reg(ppmu_pkg::REG_KD, 512);
      write_reg(ppmu_pkg::REG_ALPHA, (m % 2) ? 300 : 128);
      write_reg(ppmu_pkg::REG_MODE, m);
      write_reg(ppmu_pkg::REG_DZ, (m == 5) ? 10 : 0);
      write_reg(ppmu_pkg::REG_BOUND, 50);
      write_reg(ppmu_pkg::REG_OFFSET, (m == 7) ? 120 : 5);
      pending_q.push_back(pack_beat(32767, -32768));
      pending_q.push_back(pack_beat(-32768, 32767));
      pending_q.push_back(pack_beat(3, 0));
      pending_q.push_back(pack_beat(0, 0));
      pending_q.push_back(pack_beat(-1, 1));
      wait_idle();
    end
    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      random_setting(ph);
      for (int i = 0; i < 89; i++) begin
        case ($urandom_range(0, 3))
          0: begin
            sp = $urandom_range(0, 65535) - 32768;
            ms = $urandom_range(0, 65535) - 32768;
          end
          default: begin
            sp = $urandom_range(0, 600) - 300;
            ms = sp + $urandom_range(0, 200) - 100;
            if (ms > 32767) ms = 32767;
            if (ms < -32768) ms = -32768;
          end
        endcase
        pending_q.push_back(pack_beat(sp, ms));
      end
      wait_idle();
    end
    $display("sent %0d setpoint beats, checked %0d drive beats (%0d in deadzone)",
             n_sent, n_got, n_dz);
    $display("covered all twelve mode codes and the unused integral code");
    if (errors == 0 && drive_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
